[sv/tgad_pkg.sv]
// Shared types and constants for the TGA true-color stream decoder.
// Depends on nothing; tgad_front, tgad_back and the top level import it.
package tgad_pkg;

  localparam int unsigned HDR_LEN = 18;
  localparam logic [7:0] TGA_TYPE_TRUECOLOR = 8'd2;
  localparam logic [7:0] BPP_15 = 8'd15;
  localparam logic [7:0] BPP_16 = 8'd16;
  localparam logic [7:0] BPP_24 = 8'd24;
  localparam logic [7:0] BPP_32 = 8'd32;
  localparam logic [3:0] ABITS_0 = 4'd0;
  localparam logic [3:0] ABITS_1 = 4'd1;
  localparam logic [3:0] ABITS_4 = 4'd4;
  localparam logic [3:0] ABITS_8 = 4'd8;

  typedef enum logic [2:0] {
    ST_PIXEL      = 3'd0,
    ST_BAD_TYPE   = 3'd1,
    ST_BAD_FORMAT = 3'd2,
    ST_BAD_COUNT  = 3'd3,
    ST_TRUNCATED  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    FMT_ARGB32   = 3'd0,
    FMT_RGB32    = 3'd1,
    FMT_RGB24    = 3'd2,
    FMT_ARGB1555 = 3'd3,
    FMT_RGB565   = 3'd4,
    FMT_ARGB4444 = 3'd5
  } fmt_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_IDSKIP = 2'd2,
    PH_PIXELS = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
    logic       end_of_file;
  } in_word_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  alpha;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [19:0] pixel_index;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        last_pixel;
  } out_word_t;

  typedef struct packed {
    logic        has_pix;
    logic        has_err;
    status_t     err_status;
    fmt_t        fmt;
    logic [31:0] pix_raw;
    logic [19:0] pix_idx;
    logic        pix_last;
    logic [19:0] err_idx;
    logic [15:0] width;
    logic [15:0] height;
  } cmd_t;

endpackage

[sv/tgad_fifo.sv]
// Small first-word-fall-through queue built from registers.
// Depends on nothing but its type and depth parameters.
module tgad_fifo #(
  parameter type T = logic,
  parameter int unsigned DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     wdata,
  output logic full,
  input  logic pop,
  output T     rdata,
  output logic empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  T                mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push;
  logic            do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CW'(DEPTH))
    else $error("Queue occupancy exceeds its depth.");

endmodule

[sv/tgad_front.sv]
// Front end: header capture and checks, id skipping and pixel byte gathering.
// Depends on tgad_pkg; emits one command per word that causes any result.
module tgad_front import tgad_pkg::*; #(
  parameter int unsigned MAX_PIXELS = 1048576
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     byte_valid,
  input  in_word_t in_data,
  output logic     cmd_push,
  output cmd_t     cmd
);

  localparam int unsigned CNT_W = $clog2(MAX_PIXELS + 1);

  phase_t            phase_r, phase_nxt;
  logic [4:0]        hcnt_r, hcnt_nxt;
  logic [7:0]        skip_r, skip_nxt;
  fmt_t              fmt_r, fmt_nxt;
  logic [1:0]        pbc_r, pbc_nxt;
  logic [23:0]       partial_r, partial_nxt;
  logic [CNT_W-1:0]  done_r, done_nxt;
  logic [CNT_W-1:0]  total_m1_r, total_m1_nxt;
  logic [7:0]        hdr_r [HDR_LEN];
  logic [31:0]       product_r;
  logic              hdr_we;
  logic [4:0]        hdr_addr;
  logic [15:0]       hdr_width;
  logic [15:0]       hdr_height;

  assign hdr_width  = {hdr_r[13], hdr_r[12]};
  assign hdr_height = {hdr_r[15], hdr_r[14]};

  always_comb begin
    logic        fmt_ok;
    fmt_t        fmt_new;
    logic [3:0]  abits;
    logic [1:0]  need_m1;
    logic [31:0] v;
    logic        last;

    phase_nxt    = phase_r;
    hcnt_nxt     = hcnt_r;
    skip_nxt     = skip_r;
    fmt_nxt      = fmt_r;
    pbc_nxt      = pbc_r;
    partial_nxt  = partial_r;
    done_nxt     = done_r;
    total_m1_nxt = total_m1_r;
    cmd_push     = 1'b0;
    cmd          = '0;
    hdr_we       = 1'b0;
    hdr_addr     = hcnt_r;
    fmt_ok       = 1'b0;
    fmt_new      = FMT_ARGB32;
    abits        = in_data.data_byte[3:0];
    need_m1      = 2'd1;
    v            = '0;
    last         = 1'b0;

    if (byte_valid) begin
      if (in_data.start_of_file) begin
        phase_nxt   = PH_HEADER;
        hcnt_nxt    = '0;
        skip_nxt    = '0;
        pbc_nxt     = '0;
        partial_nxt = '0;
        done_nxt    = '0;
      end
      hdr_addr = hcnt_nxt;

      unique case (phase_nxt)
        PH_HEADER: begin
          hdr_we = (hcnt_nxt < 5'(HDR_LEN));
          if (hcnt_nxt == 5'(HDR_LEN - 1)) begin
            hcnt_nxt = 5'(HDR_LEN);
            if (hdr_r[16] == BPP_32) begin
              fmt_ok  = 1'b1;
              fmt_new = (abits == ABITS_8) ? FMT_ARGB32 : FMT_RGB32;
            end else if (hdr_r[16] == BPP_24) begin
              fmt_ok  = 1'b1;
              fmt_new = FMT_RGB24;
            end else if (hdr_r[16] == BPP_15) begin
              fmt_ok  = 1'b1;
              fmt_new = FMT_ARGB1555;
            end else if (hdr_r[16] == BPP_16) begin
              if (abits == ABITS_0) begin
                fmt_ok  = 1'b1;
                fmt_new = FMT_RGB565;
              end else if (abits == ABITS_1) begin
                fmt_ok  = 1'b1;
                fmt_new = FMT_ARGB1555;
              end else if (abits == ABITS_4) begin
                fmt_ok  = 1'b1;
                fmt_new = FMT_ARGB4444;
              end
            end
            if (hdr_r[2] != TGA_TYPE_TRUECOLOR) begin
              cmd.has_err    = 1'b1;
              cmd.err_status = ST_BAD_TYPE;
            end else if (!fmt_ok) begin
              cmd.has_err    = 1'b1;
              cmd.err_status = ST_BAD_FORMAT;
            end else if (product_r == '0 || product_r > 32'(MAX_PIXELS)) begin
              cmd.has_err    = 1'b1;
              cmd.err_status = ST_BAD_COUNT;
            end
            if (cmd.has_err) begin
              phase_nxt = PH_IDLE;
            end else begin
              fmt_nxt      = fmt_new;
              total_m1_nxt = CNT_W'(product_r - 32'd1);
              skip_nxt     = hdr_r[0];
              pbc_nxt      = '0;
              partial_nxt  = '0;
              done_nxt     = '0;
              phase_nxt    = (hdr_r[0] != '0) ? PH_IDSKIP : PH_PIXELS;
            end
          end else begin
            hcnt_nxt = hcnt_nxt + 1'b1;
          end
        end
        PH_IDSKIP: begin
          skip_nxt = skip_nxt - 1'b1;
          if (skip_nxt == '0) begin
            phase_nxt = PH_PIXELS;
          end
        end
        PH_PIXELS: begin
          unique case (fmt_r) inside
            FMT_ARGB32, FMT_RGB32: need_m1 = 2'd3;
            FMT_RGB24:             need_m1 = 2'd2;
            default:               need_m1 = 2'd1;
          endcase
          v = 32'(partial_nxt) | (32'(in_data.data_byte) << {pbc_nxt, 3'b000});
          if (pbc_nxt < need_m1) begin
            partial_nxt = v[23:0];
            pbc_nxt     = pbc_nxt + 1'b1;
          end else begin
            last         = (done_nxt == total_m1_r);
            cmd.has_pix  = 1'b1;
            cmd.fmt      = fmt_r;
            cmd.pix_raw  = v;
            cmd.pix_idx  = 20'(done_nxt);
            cmd.pix_last = last;
            pbc_nxt      = '0;
            partial_nxt  = '0;
            done_nxt     = done_nxt + 1'b1;
            if (last) begin
              phase_nxt = PH_IDLE;
            end
          end
        end
        default: begin
        end
      endcase

      if (in_data.end_of_file && phase_nxt != PH_IDLE) begin
        cmd.has_err    = 1'b1;
        cmd.err_status = ST_TRUNCATED;
        cmd.err_idx    = 20'(done_nxt);
        phase_nxt      = PH_IDLE;
      end

      if (hcnt_nxt == 5'(HDR_LEN)) begin
        cmd.width  = hdr_width;
        cmd.height = hdr_height;
      end
      cmd_push = cmd.has_pix || cmd.has_err;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr_r[hdr_addr] <= in_data.data_byte;
    end
    product_r <= 32'(hdr_width) * 32'(hdr_height);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      hcnt_r     <= '0;
      skip_r     <= '0;
      fmt_r      <= FMT_ARGB32;
      pbc_r      <= '0;
      partial_r  <= '0;
      done_r     <= '0;
      total_m1_r <= '0;
    end else begin
      phase_r    <= phase_nxt;
      hcnt_r     <= hcnt_nxt;
      skip_r     <= skip_nxt;
      fmt_r      <= fmt_nxt;
      pbc_r      <= pbc_nxt;
      partial_r  <= partial_nxt;
      done_r     <= done_nxt;
      total_m1_r <= total_m1_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push && cmd.has_err |=> phase_r == PH_IDLE)
    else $error("An error word did not return the parser to idle.");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push && cmd.has_pix && cmd.pix_last |=> phase_r == PH_IDLE)
    else $error("The parser kept running after the final pixel.");

endmodule

[sv/tgad_back.sv]
// Back end: expands gathered pixels to 8-bit ARGB and forms result words.
// Depends on tgad_pkg; a command with a pixel and an error yields two result words.
module tgad_back import tgad_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  output logic      res_push,
  output out_word_t res,
  input  logic      res_full
);

  logic second_r, second_nxt;

  always_comb begin
    logic [31:0] v;
    logic        emit_pix;

    v          = cmd.pix_raw;
    emit_pix   = cmd.has_pix && !second_r;
    second_nxt = second_r;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;

    res              = '0;
    res.image_width  = cmd.width;
    res.image_height = cmd.height;
    res.last_pixel   = 1'b1;

    if (emit_pix) begin
      res.status      = ST_PIXEL;
      res.pixel_index = cmd.pix_idx;
      res.last_pixel  = cmd.pix_last;
      res.alpha       = 8'hff;
      res.red         = v[23:16];
      res.green       = v[15:8];
      res.blue        = v[7:0];
      unique case (cmd.fmt)
        FMT_ARGB32: res.alpha = v[31:24];
        FMT_ARGB1555: begin
          res.red   = {v[14:10], v[14:12]};
          res.green = {v[9:5], v[9:7]};
          res.blue  = {v[4:0], v[4:2]};
          res.alpha = {8{v[15]}};
        end
        FMT_RGB565: begin
          res.red   = {v[15:11], v[15:13]};
          res.green = {v[10:5], v[10:9]};
          res.blue  = {v[4:0], v[4:2]};
        end
        FMT_ARGB4444: begin
          res.red   = {v[11:8], v[11:8]};
          res.green = {v[7:4], v[7:4]};
          res.blue  = {v[3:0], v[3:0]};
          res.alpha = {v[15:12], v[15:12]};
        end
        default: begin
        end
      endcase
    end else begin
      res.status      = cmd.err_status;
      res.pixel_index = cmd.err_idx;
    end

    if (cmd_valid && !res_full) begin
      res_push = 1'b1;
      if (emit_pix && cmd.has_err) begin
        second_nxt = 1'b1;
      end else begin
        second_nxt = 1'b0;
        cmd_pop    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_r <= 1'b0;
    end else begin
      second_r <= second_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    second_r |-> cmd_valid && cmd.has_pix && cmd.has_err)
    else $error("Second half of a double result lost its command.");

endmodule

[sv/tga_truecolor_stream_decoder.sv]
// Top level of the TGA true-color stream decoder.
// Depends on tgad_pkg, tgad_fifo, tgad_front and tgad_back.
//
// The decoder takes one file word (a byte with start and end marks) per cycle
// while the command queue is not full and gives one result word per pixel,
// or one error word, from a queue. The front end parses the header and
// gathers pixel bytes; a pixel's command is registered in the command queue
// and the back end moves it on into the result queue. A byte that both
// completes a pixel and ends a truncated file yields two words and holds the
// back end's result port for both; the four-word command queue absorbs that,
// so input stalls only when the result side is not drained. Header errors give
// one word and the decoder then ignores bytes until the next start of file.
module tga_truecolor_stream_decoder import tgad_pkg::*; #(
  parameter int unsigned MAX_PIXELS = 1048576
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_word_t  in_data,
  output logic      empty,
  input  logic      pop,
  output out_word_t out_data
);

  logic      byte_valid;
  logic      cmd_push;
  cmd_t      cmd_in;
  logic      cmd_full;
  logic      cmd_empty;
  logic      cmd_pop;
  cmd_t      cmd_head;
  logic      res_push;
  out_word_t res;
  logic      res_full;

  assign full       = cmd_full;
  assign byte_valid = push && !cmd_full;

  tgad_front #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_valid(byte_valid),
    .in_data   (in_data),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  tgad_fifo #(
    .T    (cmd_t),
    .DEPTH(4)
  ) u_cmd_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (cmd_push),
    .wdata(cmd_in),
    .full (cmd_full),
    .pop  (cmd_pop),
    .rdata(cmd_head),
    .empty(cmd_empty)
  );

  tgad_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(!cmd_empty),
    .cmd      (cmd_head),
    .cmd_pop  (cmd_pop),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full)
  );

  tgad_fifo #(
    .T    (out_word_t),
    .DEPTH(2)
  ) u_res_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .wdata(res),
    .full (res_full),
    .pop  (pop),
    .rdata(out_data),
    .empty(empty)
  );

endmodule
